@@ sv/sembank_pkg.sv @@
// ----------------------------------------------------------------------------
// sembank_pkg
// Shared types and constants for the semaphore bank with wait queues.
// ----------------------------------------------------------------------------
package sembank_pkg;

	localparam int NUM_SEMAPHORES = 4;
	localparam int QUEUE_DEPTH    = 8;

	localparam int KIND_W    = 2;
	localparam int SEM_W     = 2;
	localparam int PID_W     = 32;
	localparam int COUNT_W   = 16;
	localparam int INIT_W    = 64;
	localparam int SEM_IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SIGNAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELOAD = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEM_W-1:0]  semaphore_index;
		logic [PID_W-1:0]  process_id;
	} req_item_t;

	typedef struct packed {
		logic               granted;
		logic               blocked;
		logic               queue_overflow;
		logic               woke;
		logic [PID_W-1:0]   woken_pid;
		logic [COUNT_W-1:0] count_after;
	} rsp_item_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic load_out;
	} dp_cmd_t;

endpackage

@@ sv/sembank_ctrl.sv @@
// ----------------------------------------------------------------------------
// sembank_ctrl
// Sequencer: accept a transaction, execute it, then load the result register.
// ----------------------------------------------------------------------------
module sembank_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output sembank_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.load_in  = (state_q == ST_IDLE) && req_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.load_out = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> cmd.exec)
		else $error("accepted transaction not executed");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid)
		else $error("loaded result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> !cmd.load_out)
		else $error("pending result overwritten");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.exec, cmd.load_out}))
		else $error("overlapping datapath commands");

endmodule

@@ sv/sembank_dp.sv @@
// ----------------------------------------------------------------------------
// sembank_dp
// Datapath: permit counters, queue pointers, waiter memory, result register.
// ----------------------------------------------------------------------------
module sembank_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sembank_pkg::dp_cmd_t                  cmd,
	input  sembank_pkg::req_item_t                req,
	input  logic                                  wr_en,
	input  logic [sembank_pkg::INIT_W-1:0]        wr_data,
	output sembank_pkg::rsp_item_t                rsp
);

	localparam int NS = sembank_pkg::NUM_SEMAPHORES;
	localparam int CW = sembank_pkg::COUNT_W;

	function automatic logic [sembank_pkg::PTR_W-1:0] next_ptr(
		input logic [sembank_pkg::PTR_W-1:0] p
	);
		logic [sembank_pkg::PTR_W-1:0] r;
		if (p == sembank_pkg::PTR_W'(sembank_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + sembank_pkg::PTR_W'(1);
		end
		return r;
	endfunction

	sembank_pkg::req_item_t item_s1;
	logic [sembank_pkg::INIT_W-1:0] init_q;

	logic [CW-1:0]                   counts_q [NS];
	logic [sembank_pkg::PTR_W-1:0]  heads_q  [NS];
	logic [sembank_pkg::PTR_W-1:0]  tails_q  [NS];
	logic [sembank_pkg::FILL_W-1:0] fill_q   [NS];

	logic [sembank_pkg::PID_W-1:0] waiter_mem [sembank_pkg::MEM_DEPTH];
	logic [sembank_pkg::PID_W-1:0] rdata_q;

	logic               granted_q, blocked_q, overflow_q, woke_q;
	logic [CW-1:0]      count_after_q;

	logic                            sem_ok;
	logic [sembank_pkg::SEM_IDX_W-1:0] sel;
	logic [CW-1:0]                   cur_count, new_count, count_after;
	logic [sembank_pkg::FILL_W-1:0]  cur_fill;
	logic [sembank_pkg::PTR_W-1:0]   cur_head, cur_tail;
	logic                            is_reload, do_wait, do_signal;
	logic                            grant, block, overflow, wake, incr, q_full;
	logic [sembank_pkg::ADDR_W-1:0]  base_addr, waddr, raddr;

	always_comb begin
		sem_ok    = ({1'b0, item_s1.semaphore_index} < (sembank_pkg::SEM_W + 1)'(NS));
		sel       = item_s1.semaphore_index[sembank_pkg::SEM_IDX_W-1:0];
		cur_count = counts_q[sel];
		cur_fill  = fill_q[sel];
		cur_head  = heads_q[sel];
		cur_tail  = tails_q[sel];

		is_reload = (item_s1.kind == sembank_pkg::KIND_RELOAD);
		do_wait   = sem_ok && (item_s1.kind == sembank_pkg::KIND_WAIT);
		do_signal = sem_ok && (item_s1.kind == sembank_pkg::KIND_SIGNAL);

		q_full    = (cur_fill == sembank_pkg::FILL_W'(sembank_pkg::QUEUE_DEPTH));
		grant     = do_wait && (cur_count != '0);
		overflow  = do_wait && (cur_count == '0) && q_full;
		block     = do_wait && (cur_count == '0) && !q_full;
		wake      = do_signal && (cur_fill != '0);
		incr      = do_signal && (cur_fill == '0) && (cur_count != sembank_pkg::COUNT_MAX);

		if (grant) begin
			new_count = cur_count - CW'(1);
		end else if (incr) begin
			new_count = cur_count + CW'(1);
		end else begin
			new_count = cur_count;
		end

		if (!sem_ok) begin
			count_after = '0;
		end else if (is_reload) begin
			count_after = init_q[CW*sel +: CW];
		end else begin
			count_after = new_count;
		end

		base_addr = sembank_pkg::ADDR_W'(sel) *
			sembank_pkg::ADDR_W'(sembank_pkg::QUEUE_DEPTH);
		waddr     = base_addr + sembank_pkg::ADDR_W'(cur_tail);
		raddr     = base_addr + sembank_pkg::ADDR_W'(cur_head);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			for (int s = 0; s < NS; s++) begin
				counts_q[s] <= '0;
				heads_q[s]  <= '0;
				tails_q[s]  <= '0;
				fill_q[s]   <= '0;
			end
		end else begin
			if (wr_en) begin
				init_q <= wr_data;
			end
			if (cmd.exec) begin
				if (is_reload) begin
					for (int s = 0; s < NS; s++) begin
						counts_q[s] <= init_q[CW*s +: CW];
						heads_q[s]  <= '0;
						tails_q[s]  <= '0;
						fill_q[s]   <= '0;
					end
				end else begin
					if (grant || incr) begin
						counts_q[sel] <= new_count;
					end
					if (block) begin
						tails_q[sel] <= next_ptr(cur_tail);
						fill_q[sel]  <= cur_fill + sembank_pkg::FILL_W'(1);
					end
					if (wake) begin
						heads_q[sel] <= next_ptr(cur_head);
						fill_q[sel]  <= cur_fill - sembank_pkg::FILL_W'(1);
					end
				end
			end
		end
	end

	// waiter memory: at most one write and one registered read per execute cycle
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (block && !is_reload) begin
				waiter_mem[waddr] <= item_s1.process_id;
			end
			rdata_q <= waiter_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_s1 <= req;
		end
		if (cmd.exec) begin
			granted_q     <= grant;
			blocked_q     <= block;
			overflow_q    <= overflow;
			woke_q        <= wake;
			count_after_q <= count_after;
		end
		if (cmd.load_out) begin
			rsp.granted        <= granted_q;
			rsp.blocked        <= blocked_q;
			rsp.queue_overflow <= overflow_q;
			rsp.woke           <= woke_q;
			rsp.woken_pid      <= woke_q ? rdata_q : '0;
			rsp.count_after    <= count_after_q;
		end
	end

endmodule

@@ sv/semaphore_bank_with_wait_queues.sv @@
// ----------------------------------------------------------------------------
// semaphore_bank_with_wait_queues
// Bank of counting semaphores, each with a FIFO of blocked process ids.
// ----------------------------------------------------------------------------
// Each transaction passes through three steps: accept, execute (counter and
// queue pointer update plus the waiter memory write or registered read), and
// load of the result register; the next request is accepted in the cycle after
// the result register is loaded, so a new request is taken only once the
// previous transaction has left the load step. A finished result waits in its
// own register, so a new request is taken while the previous result is still
// stalled. A reload loads all counts from initial_counts and empties all
// queues in its execute step; no clearing pass is needed after reset.
// initial_counts is written through wr_en/wr_data and applies only at the
// next reload.
module semaphore_bank_with_wait_queues (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  sembank_pkg::req_item_t         req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output sembank_pkg::rsp_item_t         rsp,
	input  logic                           wr_en,
	input  logic [sembank_pkg::INIT_W-1:0] wr_data
);

	sembank_pkg::dp_cmd_t cmd;

	sembank_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sembank_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req     (req),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rsp     (rsp)
	);

endmodule

@@ tb/semaphore_bank_with_wait_queues_test.sv @@
// ----------------------------------------------------------------------------
// semaphore_bank_with_wait_queues_test
// Self-checking bench for the semaphore bank: a scripted opening walks
// resets, saturation, full wait queues and reloads. Random wait/signal
// traffic follows under several initial-count settings. Each result is
// compared to its typed script entry or a cycle-free count/queue model.
// ----------------------------------------------------------------------------
module semaphore_bank_with_wait_queues_test;

	localparam int NS = sembank_pkg::NUM_SEMAPHORES;
	localparam int QD = sembank_pkg::QUEUE_DEPTH;
	localparam int CW = sembank_pkg::COUNT_W;
	localparam logic [sembank_pkg::KIND_W-1:0] KIND_UNDEF = 2'd3;
	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 200;
	localparam int HOLD_AFTER    = 400;
	localparam int PHASE_ITEMS   = 280;
	localparam int PRINT_LIMIT   = 50;

	typedef enum {ROW_CFG, ROW_OP} row_kind_t;

	typedef struct {
		row_kind_t                         act;
		logic [sembank_pkg::INIT_W-1:0]    cfg_value;
		sembank_pkg::req_item_t            op;
		bit                                typed;
		sembank_pkg::rsp_item_t            want;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_stall;
	sembank_pkg::req_item_t         req;
	logic                           rsp_valid;
	logic                           rsp_stall;
	sembank_pkg::rsp_item_t         rsp;
	logic                           wr_en;
	logic [sembank_pkg::INIT_W-1:0] wr_data;

	// typed expectation traveling with the request, used instead of the model
	bit                             op_typed;
	sembank_pkg::rsp_item_t         op_want;

	// model state
	logic [sembank_pkg::INIT_W-1:0] reload_counts;
	logic [CW-1:0]                  permits [NS];
	logic [sembank_pkg::PID_W-1:0]  waiters [NS][QD];
	int                             q_head  [NS];
	int                             q_tail  [NS];
	int                             q_fill  [NS];

	sembank_pkg::rsp_item_t         pending_outcomes[$];
	row_t                           script[$];
	int                             mismatch_count;
	int                             rsp_seen;
	int                             quiet_cycles;

	semaphore_bank_with_wait_queues dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch (result %0d): %s", rsp_seen, msg);
		mismatch_count++;
	endtask

	function automatic sembank_pkg::rsp_item_t semaphore_outcome(
			sembank_pkg::req_item_t op);
		sembank_pkg::rsp_item_t res;
		int                     s;
		bit                     in_range;
		res = '0;
		s = int'(op.semaphore_index);
		in_range = s < NS;
		if (op.kind == sembank_pkg::KIND_RELOAD) begin
			for (int i = 0; i < NS; i++) begin
				permits[i] = reload_counts[CW*i +: CW];
				q_head[i] = 0;
				q_tail[i] = 0;
				q_fill[i] = 0;
			end
		end else if (in_range && op.kind == sembank_pkg::KIND_WAIT) begin
			if (permits[s] != '0) begin
				permits[s] = permits[s] - CW'(1);
				res.granted = 1'b1;
			end else if (q_fill[s] >= QD) begin
				res.queue_overflow = 1'b1;
			end else begin
				waiters[s][q_tail[s]] = op.process_id;
				q_tail[s] = (q_tail[s] + 1) % QD;
				q_fill[s]++;
				res.blocked = 1'b1;
			end
		end else if (in_range && op.kind == sembank_pkg::KIND_SIGNAL) begin
			if (q_fill[s] > 0) begin
				res.woken_pid = waiters[s][q_head[s]];
				q_head[s] = (q_head[s] + 1) % QD;
				q_fill[s]--;
				res.woke = 1'b1;
			end else if (permits[s] != sembank_pkg::COUNT_MAX) begin
				permits[s] = permits[s] + CW'(1);
			end
		end
		if (in_range)
			res.count_after = permits[s];
		return res;
	endfunction

	task automatic compare_outcome(sembank_pkg::rsp_item_t got,
			sembank_pkg::rsp_item_t want);
		if (got.granted !== want.granted)
			report_mismatch($sformatf("granted %b, want %b", got.granted, want.granted));
		if (got.blocked !== want.blocked)
			report_mismatch($sformatf("blocked %b, want %b", got.blocked, want.blocked));
		if (got.queue_overflow !== want.queue_overflow)
			report_mismatch($sformatf("queue_overflow %b, want %b",
				got.queue_overflow, want.queue_overflow));
		if (got.woke !== want.woke)
			report_mismatch($sformatf("woke %b, want %b", got.woke, want.woke));
		if (got.woken_pid !== want.woken_pid)
			report_mismatch($sformatf("woken_pid %h, want %h", got.woken_pid, want.woken_pid));
		if (got.count_after !== want.count_after)
			report_mismatch($sformatf("count_after %h, want %h",
				got.count_after, want.count_after));
	endtask

	// config, input and output transactions, all sampled at the rising edge
	always @(posedge clk) begin
		sembank_pkg::rsp_item_t predicted;
		bit                     moved;
		moved = 1'b0;
		if (arst_n) begin
			if (wr_en)
				reload_counts = wr_data;
			if (req_valid && !req_stall) begin
				predicted = semaphore_outcome(req);
				pending_outcomes.push_back(op_typed ? op_want : predicted);
				moved = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					compare_outcome(rsp, pending_outcomes.pop_front());
				end
				rsp_seen++;
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: stall mode changes after runs of random length, plus one long hold
	initial begin : receiver
		int mode;
		int left;
		bit held;
		mode = 0;
		left = 0;
		held = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && rsp_seen >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(3);
				left = $urandom_range(16, 64);
			end
			left--;
			case (mode)
			0: rsp_stall = 1'b0;
			1: rsp_stall = ($urandom_range(3) == 0);
			2: rsp_stall = ($urandom_range(3) != 0);
			default: rsp_stall = ~rsp_stall;
			endcase
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer(sembank_pkg::req_item_t op, bit typed,
			sembank_pkg::rsp_item_t want);
		req_valid = 1'b1;
		req = op;
		op_typed = typed;
		op_want = want;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_for(int cycles);
		req_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_counts(logic [sembank_pkg::INIT_W-1:0] value);
		wait_drained();
		wr_en = 1'b1;
		wr_data = value;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic add_cfg(logic [sembank_pkg::INIT_W-1:0] value);
		row_t row;
		row = '{act: ROW_CFG, cfg_value: value, op: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endtask

	task automatic add_op(logic [sembank_pkg::KIND_W-1:0] kind, int sem,
			logic [sembank_pkg::PID_W-1:0] pid);
		row_t row;
		row = '{act: ROW_OP, cfg_value: '0, op: '0, typed: 1'b0, want: '0};
		row.op.kind = kind;
		row.op.semaphore_index = sembank_pkg::SEM_W'(sem);
		row.op.process_id = pid;
		script.push_back(row);
	endtask

	task automatic add_checked(logic [sembank_pkg::KIND_W-1:0] kind, int sem,
			logic [sembank_pkg::PID_W-1:0] pid,
			logic g, logic b, logic o, logic w, logic [sembank_pkg::PID_W-1:0] wpid,
			logic [CW-1:0] cnt);
		add_op(kind, sem, pid);
		script[$].typed = 1'b1;
		script[$].want = '{granted: g, blocked: b, queue_overflow: o, woke: w,
			woken_pid: wpid, count_after: cnt};
	endtask

	function automatic sembank_pkg::req_item_t random_op(int wait_pct);
		sembank_pkg::req_item_t op;
		int                     roll;
		roll = $urandom_range(99);
		if (roll < wait_pct)
			op.kind = sembank_pkg::KIND_WAIT;
		else if (roll < 97)
			op.kind = sembank_pkg::KIND_SIGNAL;
		else if (roll < 98)
			op.kind = sembank_pkg::KIND_RELOAD;
		else
			op.kind = KIND_UNDEF;
		op.semaphore_index = sembank_pkg::SEM_W'($urandom_range(NS - 1));
		case ($urandom_range(9))
		0: op.process_id = '0;
		1: op.process_id = '1;
		default: op.process_id = $urandom;
		endcase
		return op;
	endfunction

	task automatic random_phase(logic [sembank_pkg::INIT_W-1:0] counts, int wait_pct,
			bit mid_pause);
		sembank_pkg::req_item_t op;
		int                     sent;
		int                     burst;
		write_counts(counts);
		op = '0;
		op.kind = sembank_pkg::KIND_RELOAD;
		offer(op, 1'b0, '0);
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
				offer(random_op(wait_pct), 1'b0, '0);
				sent++;
				if (mid_pause && sent == PHASE_ITEMS / 2)
					wait_drained();
			end
			if ($urandom_range(3) != 0)
				idle_for($urandom_range(1, 6));
		end
	endtask

	function automatic logic [sembank_pkg::INIT_W-1:0] small_counts();
		logic [sembank_pkg::INIT_W-1:0] v;
		v = '0;
		for (int i = 0; i < NS; i++)
			v[CW*i +: CW] = CW'($urandom_range(3));
		return v;
	endfunction

	initial begin : stimulus
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		op_typed = 1'b0;
		op_want = '0;
		wr_en = 1'b0;
		wr_data = '0;
		mismatch_count = 0;
		rsp_seen = 0;
		quiet_cycles = 0;
		reload_counts = '0;
		for (int i = 0; i < NS; i++) begin
			permits[i] = '0;
			q_head[i] = 0;
			q_tail[i] = 0;
			q_fill[i] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// counts are zero out of reset: wait blocks, signal hands the permit over
		add_checked(sembank_pkg::KIND_WAIT,   0, 32'h0,         0, 1, 0, 0, 32'h0, 16'h0);
		add_checked(sembank_pkg::KIND_SIGNAL, 0, 32'h1234_5678, 0, 0, 0, 1, 32'h0, 16'h0);
		add_checked(KIND_UNDEF,               1, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'h0, 16'h0);
		add_checked(sembank_pkg::KIND_SIGNAL, 2, 32'h0,         0, 0, 0, 0, 32'h0, 16'h1);
		add_cfg(64'h8000_0000_0001_FFFF);
		add_checked(sembank_pkg::KIND_RELOAD, 0, 32'h0,         0, 0, 0, 0, 32'h0, 16'hFFFF);
		// saturated count does not move on a signal
		add_checked(sembank_pkg::KIND_SIGNAL, 0, 32'h0,         0, 0, 0, 0, 32'h0, 16'hFFFF);
		add_checked(KIND_UNDEF,               0, 32'h0,         0, 0, 0, 0, 32'h0, 16'hFFFF);
		add_checked(sembank_pkg::KIND_WAIT,   0, 32'hFFFF_FFFF, 1, 0, 0, 0, 32'h0, 16'hFFFE);
		add_checked(sembank_pkg::KIND_WAIT,   1, 32'h1,         1, 0, 0, 0, 32'h0, 16'h0);
		// fill semaphore 1's queue, then one more wait overflows
		for (int k = 0; k < QD; k++)
			add_op(sembank_pkg::KIND_WAIT, 1, 32'hA5A5_0000 | (32'h1 << (k + 8)));
		add_checked(sembank_pkg::KIND_WAIT,   1, 32'hDEAD_BEEF, 0, 0, 1, 0, 32'h0, 16'h0);
		add_op(sembank_pkg::KIND_SIGNAL, 1, 32'h0);
		add_op(sembank_pkg::KIND_SIGNAL, 3, 32'h0);
		// reload empties the queues even with waiters left
		add_checked(sembank_pkg::KIND_RELOAD, 2, 32'h0,         0, 0, 0, 0, 32'h0, 16'h0);
		add_checked(sembank_pkg::KIND_SIGNAL, 1, 32'h0,         0, 0, 0, 0, 32'h0, 16'h2);
		add_cfg(64'h0);
		add_checked(sembank_pkg::KIND_RELOAD, 3, 32'h0,         0, 0, 0, 0, 32'h0, 16'h0);
		add_checked(sembank_pkg::KIND_WAIT,   3, 32'h5555_AAAA, 0, 1, 0, 0, 32'h0, 16'h0);

		foreach (script[i]) begin
			if (script[i].act == ROW_CFG)
				write_counts(script[i].cfg_value);
			else
				offer(script[i].op, script[i].typed, script[i].want);
		end
		op_typed = 1'b0;

		random_phase('0, 70, 1'b0);
		random_phase('1, 30, 1'b0);
		random_phase(small_counts(), 55, 1'b1);
		random_phase({$urandom, $urandom}, 50, 1'b0);
		random_phase(small_counts(), 45, 1'b0);

		wait_drained();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
sv/sembank_pkg.sv
sv/sembank_ctrl.sv
sv/sembank_dp.sv
sv/semaphore_bank_with_wait_queues.sv
tb/semaphore_bank_with_wait_queues_test.sv
